[hdl/epr_pkg.sv]
// ----------------------------------------------------------------------------
// epr_pkg
// Shared types and constants of the echo pulse ranger.
// ----------------------------------------------------------------------------
package epr_pkg;

  localparam int unsigned PeriodW   = 16;
  localparam int unsigned StampW    = 32;
  localparam int unsigned WidthW    = 16;
  localparam int unsigned DistW     = 17;
  localparam int unsigned VelW      = 22;
  localparam int unsigned AccW      = 26;

  localparam logic [PeriodW-1:0] PeriodReset = 16'd10;
  localparam logic [WidthW-1:0]  WidthMax    = 16'hFFFF;

  // floor(x / 10) = (x * DivRecip) >> DivShift for x < 2^22
  localparam int unsigned        ProdW    = 21;
  localparam logic [ProdW-1:0]   DivRecip = 21'd1677722;
  localparam int unsigned        DivShift = 24;

  localparam logic KindTick = 1'b0;
  localparam logic KindEdge = 1'b1;

  typedef enum logic [2:0] {
    StWaitFirst  = 3'b001,
    StWaitSecond = 3'b010,
    StDisarmed   = 3'b100
  } echo_stage_e;

  typedef struct packed {
    logic              have_echo;
    logic [WidthW-1:0] echo_width;
  } echo_state_t;

  typedef struct packed {
    logic fire;
    logic updated;
  } kin_status_t;

endpackage

[hdl/epr_if.sv]
// ----------------------------------------------------------------------------
// epr_in_if / epr_out_if
// Valid/ready channels for echo ranger events and results.
// ----------------------------------------------------------------------------
interface epr_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [epr_pkg::StampW-1:0]    time_us;

  modport source (output valid, kind, time_us, input ready);
  modport sink   (input valid, kind, time_us, output ready);
endinterface

interface epr_out_if;
  logic                               valid;
  logic                               ready;
  logic                               fire_trigger;
  logic                               updated;
  logic        [epr_pkg::DistW-1:0]   distance_out;
  logic signed [epr_pkg::VelW-1:0]    velocity_out;
  logic signed [epr_pkg::AccW-1:0]    accel_out;

  modport source (output valid, fire_trigger, updated, distance_out, velocity_out,
                  accel_out, input ready);
  modport sink   (input valid, fire_trigger, updated, distance_out, velocity_out,
                  accel_out, output ready);
endinterface

[hdl/epr_echo_timer.sv]
// ----------------------------------------------------------------------------
// epr_echo_timer
// Arm/start/stop tracking of the echo pulse and width capture.
// ----------------------------------------------------------------------------
module epr_echo_timer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        kind_i,
  input  logic [epr_pkg::StampW-1:0]  time_us_i,
  input  logic                        fire_i,
  output epr_pkg::echo_state_t        echo_o
);

  epr_pkg::echo_stage_e               stage_q, stage_d;
  logic [epr_pkg::StampW-1:0]         start_q, start_d;
  logic [epr_pkg::WidthW-1:0]         width_q, width_d;
  logic                               have_q, have_d;
  logic [epr_pkg::StampW-1:0]         diff;
  logic                               edge_hit;

  assign edge_hit = adv_i && (kind_i == epr_pkg::KindEdge);
  assign diff     = time_us_i - start_q;

  always_comb begin
    stage_d = stage_q;
    start_d = start_q;
    width_d = width_q;
    have_d  = have_q;
    if (fire_i) begin
      stage_d = epr_pkg::StWaitFirst;
    end else if (edge_hit) begin
      unique case (stage_q)
        epr_pkg::StWaitFirst: begin
          start_d = time_us_i;
          stage_d = epr_pkg::StWaitSecond;
        end
        epr_pkg::StWaitSecond: begin
          // width saturates at the 16-bit limit
          width_d = (diff > {{(epr_pkg::StampW-epr_pkg::WidthW){1'b0}}, epr_pkg::WidthMax})
                    ? epr_pkg::WidthMax : diff[epr_pkg::WidthW-1:0];
          have_d  = 1'b1;
          stage_d = epr_pkg::StDisarmed;
        end
        default: begin
          stage_d = stage_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= epr_pkg::StDisarmed;
      start_q <= '0;
      width_q <= '0;
      have_q  <= 1'b0;
    end else begin
      stage_q <= stage_d;
      start_q <= start_d;
      width_q <= width_d;
      have_q  <= have_d;
    end
  end

  assign echo_o.have_echo  = have_q;
  assign echo_o.echo_width = width_q;

endmodule

[hdl/epr_kinematics.sv]
// ----------------------------------------------------------------------------
// epr_kinematics
// Tick scheduler, distance conversion and velocity/acceleration update.
// ----------------------------------------------------------------------------
module epr_kinematics (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic        [epr_pkg::PeriodW-1:0] cfg_wdata_i,
  input  logic                               adv_i,
  input  logic                               kind_i,
  input  epr_pkg::echo_state_t               echo_i,
  output epr_pkg::kin_status_t               status_o,
  output logic        [epr_pkg::DistW-1:0]   distance_o,
  output logic signed [epr_pkg::VelW-1:0]    velocity_o,
  output logic signed [epr_pkg::AccW-1:0]    accel_o
);

  logic        [epr_pkg::PeriodW-1:0] period_q;
  logic        [epr_pkg::PeriodW-1:0] count_q, count_d, count_inc;
  logic        [epr_pkg::DistW-1:0]   dist_q, dist_d;
  logic signed [epr_pkg::VelW-1:0]    vel_q, vel_d;
  logic signed [epr_pkg::AccW-1:0]    acc_q, acc_d;
  logic                               tick, fire, upd;

  logic        [epr_pkg::ProdW-1:0]   x17;
  logic        [2*epr_pkg::ProdW-1:0] prod;
  logic        [epr_pkg::DistW-1:0]   dist_new;
  logic signed [epr_pkg::DistW:0]     dd;
  logic signed [epr_pkg::VelW-1:0]    dd_w;
  logic signed [epr_pkg::VelW:0]      dv;
  logic signed [epr_pkg::AccW-1:0]    dv_w;

  assign tick      = adv_i && (kind_i == epr_pkg::KindTick);
  assign count_inc = count_q + 1'b1;
  assign fire      = tick && (count_inc >= period_q);
  assign upd       = fire && echo_i.have_echo;
  assign count_d   = tick ? (fire ? '0 : count_inc) : count_q;

  // width * 17 / 10 by reciprocal multiply
  assign x17      = {1'b0, echo_i.echo_width, 4'b0000} +
                    {{(epr_pkg::ProdW-epr_pkg::WidthW){1'b0}}, echo_i.echo_width};
  assign prod     = x17 * epr_pkg::DivRecip;
  assign dist_new = prod[epr_pkg::DivShift +: epr_pkg::DistW];

  // x10 as (x << 3) + (x << 1)
  assign dd    = $signed({1'b0, dist_new}) - $signed({1'b0, dist_q});
  assign dd_w  = {{(epr_pkg::VelW-epr_pkg::DistW-1){dd[epr_pkg::DistW]}}, dd};
  assign vel_d = upd ? ((dd_w <<< 3) + (dd_w <<< 1)) : vel_q;
  assign dv    = {vel_d[epr_pkg::VelW-1], vel_d} - {vel_q[epr_pkg::VelW-1], vel_q};
  assign dv_w  = {{(epr_pkg::AccW-epr_pkg::VelW-1){dv[epr_pkg::VelW]}}, dv};
  assign acc_d = upd ? ((dv_w <<< 3) + (dv_w <<< 1)) : acc_q;
  assign dist_d = upd ? dist_new : dist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= epr_pkg::PeriodReset;
      count_q  <= '0;
      dist_q   <= '0;
      vel_q    <= '0;
      acc_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        period_q <= cfg_wdata_i;
      end
      count_q <= count_d;
      dist_q  <= dist_d;
      vel_q   <= vel_d;
      acc_q   <= acc_d;
    end
  end

  assign status_o.fire    = fire;
  assign status_o.updated = upd;
  assign distance_o       = dist_q;
  assign velocity_o       = vel_q;
  assign accel_o          = acc_q;

endmodule

[hdl/echo_pulse_ranger.sv]
// ----------------------------------------------------------------------------
// echo_pulse_ranger
// Ultrasonic echo ranger: echo width capture, distance, velocity, acceleration.
// ----------------------------------------------------------------------------
// Takes one event beat per cycle while results drain (scheduler tick or
// echo edge with a microsecond stamp) and returns exactly one result beat
// for each, in order. A beat waits in the input register until the result
// register is free or draining; the state update and the result register
// load then happen together. While results drain, throughput is one beat
// per clock, set by the single-pass update between the input register and
// the state/result registers. The first edge after a trigger records the
// start time, the second stores the saturated echo width. Every period_ticks
// ticks the trigger fires and, once any echo has been seen, distance
// (0.01 cm), velocity and acceleration are refreshed from the latest stored
// width. period_ticks is written through cfg_we_i/cfg_wdata_i, by the user
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module echo_pulse_ranger (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [epr_pkg::PeriodW-1:0] cfg_wdata_i,
  epr_in_if.sink                      req_i,
  epr_out_if.source                   rsp_o
);

  // input register
  logic                       in_vld_q, in_vld_d;
  logic                       in_kind_q;
  logic [epr_pkg::StampW-1:0] in_time_q;

  // result register: flags here, the measurement fields are the state
  // registers themselves (they only move when a result is loaded)
  logic                       out_vld_q, out_vld_d;
  logic                       out_fire_q;
  logic                       out_upd_q;

  logic                       adv;
  logic                       in_take;
  epr_pkg::echo_state_t       echo;
  epr_pkg::kin_status_t       status;

  // advance when an item waits and the result slot is free or draining
  assign adv       = in_vld_q && (!out_vld_q || rsp_o.ready);
  assign req_i.ready = !in_vld_q || adv;
  assign in_take   = req_i.valid && req_i.ready;

  assign in_vld_d  = in_take ? 1'b1 : (adv ? 1'b0 : in_vld_q);
  assign out_vld_d = adv ? 1'b1 : ((out_vld_q && rsp_o.ready) ? 1'b0 : out_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_kind_q <= req_i.kind;
      in_time_q <= req_i.time_us;
    end
    if (adv) begin
      out_fire_q <= status.fire;
      out_upd_q  <= status.updated;
    end
  end

  epr_echo_timer u_echo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .kind_i    (in_kind_q),
    .time_us_i (in_time_q),
    .fire_i    (status.fire),
    .echo_o    (echo)
  );

  epr_kinematics u_kin (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .adv_i       (adv),
    .kind_i      (in_kind_q),
    .echo_i      (echo),
    .status_o    (status),
    .distance_o  (rsp_o.distance_out),
    .velocity_o  (rsp_o.velocity_out),
    .accel_o     (rsp_o.accel_out)
  );

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.fire_trigger = out_fire_q;
  assign rsp_o.updated      = out_upd_q;

`ifndef ASSERT_OFF
  // a recompute only ever happens on a period boundary
  a_upd_fires: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_upd_q) |-> out_fire_q)
    else $error("updated without trigger");

  // input back-pressure only while a beat is blocked behind a stalled result
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> (in_vld_q && out_vld_q && !rsp_o.ready))
    else $error("input stalled without cause");

  // the distance field moves only with a recompute
  a_dist_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !status.updated) |=> $stable(rsp_o.distance_out))
    else $error("distance changed without update");
`endif

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the echo pulse ranger.
// ----------------------------------------------------------------------------
// A directed table comes first: reset period, the disarmed and wrapping echo
// edges, width saturation, the sticky echo flag, the largest velocity and
// acceleration swings, and period zero. Then a long period is run to its
// trigger, the period is lowered below the running count, and random echo
// rounds follow at several periods. Each beat is predicted at acceptance and
// each result beat is compared field by field, in order. Both sides idle at
// random.
// ----------------------------------------------------------------------------
module testbench;

  localparam longint CycleLimit = 64'd2_000_000;

  // One result beat as the block presents it.
  typedef struct packed {
    logic                               fire;
    logic                               updated;
    logic        [epr_pkg::DistW-1:0]   distance;
    logic signed [epr_pkg::VelW-1:0]    velocity;
    logic signed [epr_pkg::AccW-1:0]    accel;
  } ranging_t;

  // Directed plan: a tick or an edge repeated reps times, or a period write.
  typedef enum logic [1:0] {
    RowTick,
    RowEdge,
    RowPeriod
  } row_op_e;

  typedef struct {
    row_op_e     op;
    logic [31:0] value;  // edge stamp, or new period
    int          reps;
    bit          typed;  // want below holds the result for this row
    ranging_t    want;
  } plan_row_t;

  localparam int PlanRows = 23;
  localparam int LongPeriod = 40;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  logic [epr_pkg::PeriodW-1:0] cfg_wdata;

  epr_in_if  req_if ();
  epr_out_if rsp_if ();

  echo_pulse_ranger i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  always #6 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Ranger model state, advanced at every accepted event beat
  // --------------------------------------------------------------------------
  logic [epr_pkg::PeriodW-1:0] period_q;
  logic [epr_pkg::PeriodW-1:0] ticks_q;
  epr_pkg::echo_stage_e        stage_q;
  logic [epr_pkg::StampW-1:0]  start_q;
  logic [epr_pkg::WidthW-1:0]  width_q;
  logic                        have_echo_q;
  int                          dist_q;
  int                          vel_q;
  int                          acc_q;

  ranging_t ranging_q[$];   // results still owed by the block, oldest first
  bit       last_fire;      // trigger outcome of the last accepted beat

  int mismatches;
  int items_sent;
  int edges_sent;
  int results_seen;
  int updates_seen;
  int fires_seen;
  int saturated;
  longint cycles;

  int send_calm;
  int recv_calm;

  function automatic ranging_t step_ranger(logic kind, logic [epr_pkg::StampW-1:0] stamp);
    ranging_t                   r;
    logic [epr_pkg::StampW-1:0] delta;
    int                         dist_new;
    int                         vel_old;
    r = '0;
    if (kind == epr_pkg::KindEdge) begin
      if (stage_q == epr_pkg::StWaitFirst) begin
        start_q = stamp;
        stage_q = epr_pkg::StWaitSecond;
      end else if (stage_q == epr_pkg::StWaitSecond) begin
        // width is the wrapped difference, clipped to 16 bits
        delta = stamp - start_q;
        if (delta > {{(epr_pkg::StampW-epr_pkg::WidthW){1'b0}}, epr_pkg::WidthMax}) begin
          width_q = epr_pkg::WidthMax;
          saturated++;
        end else begin
          width_q = delta[epr_pkg::WidthW-1:0];
        end
        have_echo_q = 1'b1;
        stage_q     = epr_pkg::StDisarmed;
      end
      // a disarmed block drops the edge
    end else begin
      ticks_q = ticks_q + 1'b1;
      if (ticks_q >= period_q) begin
        ticks_q = '0;
        if (have_echo_q) begin
          // flag is sticky: the last stored width is reused
          dist_new  = int'((32'(width_q) * 17) / 10);
          vel_old   = vel_q;
          vel_q     = 10 * (dist_new - dist_q);
          acc_q     = 10 * (vel_q - vel_old);
          dist_q    = dist_new;
          r.updated = 1'b1;
        end
        r.fire  = 1'b1;
        stage_q = epr_pkg::StWaitFirst;
      end
    end
    r.distance = dist_q[epr_pkg::DistW-1:0];
    r.velocity = vel_q[epr_pkg::VelW-1:0];
    r.accel    = acc_q[epr_pkg::AccW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("ranger mismatch: %s at result %0d: got %0d, expected %0d",
             what, results_seen, got, want);
  endtask

  // Mostly no gap, some short, a few long; now and then a calm stretch.
  function automatic int idle_len(inout int calm);
    int roll;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      calm = $urandom_range(20, 100);
      return 0;
    end
    if (roll < 60) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // Event side: drive at the falling edge, handshake seen at the rising edge
  // --------------------------------------------------------------------------
  task automatic send_event(input logic kind, input logic [epr_pkg::StampW-1:0] stamp,
                            input bit typed, input ranging_t typed_want);
    int       gap;
    ranging_t predicted;
    gap = idle_len(send_calm);
    @(negedge clk_i);
    if (gap > 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid   = 1'b1;
    req_if.kind    = kind;
    req_if.time_us = stamp;
    do @(posedge clk_i); while (!req_if.ready);
    predicted = step_ranger(kind, stamp);
    last_fire = predicted.fire;
    ranging_q.push_back(typed ? typed_want : predicted);
    items_sent++;
    if (kind == epr_pkg::KindEdge) edges_sent++;
  endtask

  // Sender holds off until every owed result has come back.
  task automatic drain();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (ranging_q.size() != 0) @(posedge clk_i);
  endtask

  // Period writes only land on an idle block; every beat has its result,
  // so an empty queue means nothing is in flight.
  task automatic write_period(input logic [epr_pkg::PeriodW-1:0] value);
    drain();
    @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk_i);
    cfg_we    = 1'b0;
    period_q  = value;
  endtask

  function automatic logic [epr_pkg::StampW-1:0] pick_start();
    // a quarter of the starts lie near the top of the stamp range, so the closing edge often wraps
    if ($urandom_range(0, 3) == 0) return 32'hFFFF_FFFF - $urandom_range(0, 300);
    return $urandom();
  endfunction

  function automatic logic [epr_pkg::StampW-1:0] pick_width();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 200);
      1:       return $urandom_range(0, 65535);
      2:       return $urandom_range(65500, 65600);   // around saturation
      default: return $urandom();
    endcase
  endfunction

  // One measurement round: mostly a clean echo pair, sometimes a lone or
  // extra edge, sometimes random noise; then ticks until the trigger fires.
  task automatic ranging_round();
    int          pick;
    logic [31:0] t0;
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      t0 = pick_start();
      send_event(epr_pkg::KindEdge, t0, 1'b0, '0);
      send_event(epr_pkg::KindEdge, t0 + pick_width(), 1'b0, '0);
    end else if (pick == 7) begin
      t0 = pick_start();
      send_event(epr_pkg::KindEdge, t0, 1'b0, '0);
      if ($urandom_range(0, 1) == 1) begin
        send_event(epr_pkg::KindEdge, t0 + pick_width(), 1'b0, '0);
        send_event(epr_pkg::KindEdge, $urandom(), 1'b0, '0);  // dropped, block disarmed
      end
    end else begin
      repeat ($urandom_range(1, 4))
        send_event(logic'($urandom_range(0, 1)), $urandom(), 1'b0, '0);
    end
    do send_event(epr_pkg::KindTick, $urandom(), 1'b0, '0); while (!last_fire);
  endtask

  // --------------------------------------------------------------------------
  // Result side: ready toggles at the falling edge, beats checked at rising
  // --------------------------------------------------------------------------
  initial begin
    int stall_left;
    stall_left   = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        rsp_if.ready = 1'b0;
        stall_left--;
      end else begin
        rsp_if.ready = rst_ni;
        stall_left   = rst_ni ? idle_len(recv_calm) : 0;
      end
    end
  end

  always @(posedge clk_i) begin
    ranging_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      results_seen++;
      if (rsp_if.updated) updates_seen++;
      if (rsp_if.fire_trigger) fires_seen++;
      if (ranging_q.size() == 0) begin
        report_mismatch("result beat with nothing owed", 1, 0);
      end else begin
        want = ranging_q.pop_front();
        if (rsp_if.fire_trigger !== want.fire)
          report_mismatch("fire_trigger", longint'(rsp_if.fire_trigger), longint'(want.fire));
        if (rsp_if.updated !== want.updated)
          report_mismatch("updated", longint'(rsp_if.updated), longint'(want.updated));
        if (rsp_if.distance_out !== want.distance)
          report_mismatch("distance_out", longint'(rsp_if.distance_out),
                          longint'(want.distance));
        if (rsp_if.velocity_out !== want.velocity)
          report_mismatch("velocity_out", longint'(rsp_if.velocity_out),
                          longint'(want.velocity));
        if (rsp_if.accel_out !== want.accel)
          report_mismatch("accel_out", longint'(rsp_if.accel_out), longint'(want.accel));
      end
    end
  end

  // Watchdog: a hung handshake ends the run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    plan_row_t plan [PlanRows];
    int        phase_end;

    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    req_if.valid   = 1'b0;
    req_if.kind    = epr_pkg::KindTick;
    req_if.time_us = '0;

    period_q    = epr_pkg::PeriodReset;
    ticks_q     = '0;
    stage_q     = epr_pkg::StDisarmed;
    start_q     = '0;
    width_q     = '0;
    have_echo_q = 1'b0;
    dist_q      = 0;
    vel_q       = 0;
    acc_q       = 0;

    // Typed rows hold results that follow straight from reset and the
    // stamps; all other rows go through the model.
    plan = '{
      // reset period is 10: nine quiet ticks, then a bare trigger
      '{RowTick,   32'd0,          9, 1'b0, '0},
      '{RowTick,   32'd0,          1, 1'b1, '{1'b1, 1'b0, 17'd0, 22'sd0, 26'sd0}},
      // stamp wraps past zero: width 0x20; then a dropped edge
      '{RowEdge,   32'hFFFF_FFF0,  1, 1'b1, '0},
      '{RowEdge,   32'h0000_0010,  1, 1'b1, '0},
      '{RowEdge,   32'h0000_0007,  1, 1'b1, '0},
      '{RowPeriod, 32'd1,          1, 1'b0, '0},
      '{RowTick,   32'd0,          1, 1'b1, '{1'b1, 1'b1, 17'd54, 22'sd540, 26'sd5400}},
      // width far past 16 bits saturates, largest distance
      '{RowEdge,   32'h0000_0000,  1, 1'b0, '0},
      '{RowEdge,   32'hFFFF_FFFF,  1, 1'b0, '0},
      '{RowTick,   32'hFFFF_FFFF,  1, 1'b0, '0},
      // no new echo: sticky flag recomputes from the held width
      '{RowTick,   32'd0,          1, 1'b0, '0},
      // zero width: full swing down
      '{RowEdge,   32'd1000,       1, 1'b0, '0},
      '{RowEdge,   32'd1000,       1, 1'b0, '0},
      '{RowTick,   32'd0,          1, 1'b0, '0},
      // exactly 65535: largest positive velocity and acceleration
      '{RowEdge,   32'd50,         1, 1'b0, '0},
      '{RowEdge,   32'd65585,      1, 1'b0, '0},
      '{RowTick,   32'd0,          1, 1'b0, '0},
      // back to zero: most negative acceleration
      '{RowEdge,   32'd9,          1, 1'b0, '0},
      '{RowEdge,   32'd9,          1, 1'b0, '0},
      '{RowTick,   32'd0,          1, 1'b0, '0},
      // period zero: every tick fires
      '{RowPeriod, 32'd0,          1, 1'b0, '0},
      '{RowTick,   32'd0,          1, 1'b0, '0},
      '{RowTick,   32'd0,          1, 1'b0, '0}
    };

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].op == RowPeriod) begin
        write_period(plan[i].value[epr_pkg::PeriodW-1:0]);
      end else begin
        repeat (plan[i].reps)
          send_event(plan[i].op == RowEdge ? epr_pkg::KindEdge : epr_pkg::KindTick,
                     plan[i].value, plan[i].typed, plan[i].want);
      end
    end

    // Long period: one echo, then a full wait to the trigger.
    write_period(16'(LongPeriod));
    send_event(epr_pkg::KindEdge, 32'h8000_0000, 1'b0, '0);
    send_event(epr_pkg::KindEdge, 32'h8000_0000 + pick_width(), 1'b0, '0);
    repeat (LongPeriod) send_event(epr_pkg::KindTick, $urandom(), 1'b0, '0);
    // Count left at 25, then the period drops under it: next tick fires.
    repeat (25) send_event(epr_pkg::KindTick, $urandom(), 1'b0, '0);
    write_period(16'd3);

    // Random rounds; each period change drains the block first.
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0:       ;
        1:       write_period(16'd1);
        2:       write_period(16'd2);
        3:       write_period(16'd0);
        4:       write_period(16'd7);
        5:       write_period(16'($urandom_range(1, 12)));
        default: write_period(16'd4);
      endcase
      phase_end = items_sent + 60;
      while (items_sent < phase_end) ranging_round();
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (ranging_q.size() != 0)
      report_mismatch("results never returned", longint'(ranging_q.size()), 0);

    $display("run covered %0d event beats (%0d echo edges), %0d result beats checked",
             items_sent, edges_sent, results_seen);
    $display("  %0d trigger pulses, %0d recomputes, %0d saturated echo widths",
             fires_seen, updates_seen, saturated);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
